### hw/rtl/lot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lot_pkg: shared types and helpers for the LRU order tracker
// Id width, link memory address width, FSM states, link port structs and
// the functions that give the initial descending order and clamp the count.
// ----------------------------------------------------------------------------
package lot_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ID_W        = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic {
		ST_IDLE,
		ST_UNLINK
	} state_t;

	typedef struct packed {
		logic  nn_we;
		addr_t nn_addr;
		id_t   nn_data;
		logic  po_we;
		addr_t po_addr;
		id_t   po_data;
	} link_wr_t;

	typedef struct packed {
		id_t nn;
		id_t po;
	} link_rd_t;

	function automatic addr_t addr_of(input id_t id);
		id_t m;
		m = id - ID_W'(1);
		return m[ADDR_W-1:0];
	endfunction

	function automatic id_t nn_init(input id_t id);
		return (id >= ID_W'(2)) ? id - ID_W'(1) : '0;
	endfunction

	function automatic id_t po_init(input id_t id, input id_t count);
		return (id < count) ? id + ID_W'(1) : '0;
	endfunction

	function automatic id_t clamp_count(input id_t v);
		id_t r;
		r = v;
		if (v == '0) begin
			r = ID_W'(1);
		end else if (v > ID_W'(MAX_ENTRIES)) begin
			r = ID_W'(MAX_ENTRIES);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lot_link_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lot_link_mem: recency link memories
// Holds next_newer and prev_older, one write and one registered read each.
// Entries not written since reset or a rebuild read as the initial order.
// ----------------------------------------------------------------------------
module lot_link_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire lot_pkg::id_t      count,
	input  wire logic              rd_en,
	input  wire lot_pkg::id_t      rd_id,
	input  wire lot_pkg::link_wr_t wr,
	output lot_pkg::link_rd_t      rd
);

	lot_pkg::id_t nn_mem [lot_pkg::MAX_ENTRIES];
	lot_pkg::id_t po_mem [lot_pkg::MAX_ENTRIES];

	logic [lot_pkg::MAX_ENTRIES-1:0] nn_vld_q;
	logic [lot_pkg::MAX_ENTRIES-1:0] po_vld_q;

	lot_pkg::id_t  nn_rd_q;
	lot_pkg::id_t  po_rd_q;
	logic          nn_rd_vld_q;
	logic          po_rd_vld_q;
	lot_pkg::id_t  rd_id_q;
	lot_pkg::addr_t rd_addr;

	assign rd_addr = lot_pkg::addr_of(rd_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_vld_q <= '0;
			po_vld_q <= '0;
		end else if (clear) begin
			nn_vld_q <= '0;
			po_vld_q <= '0;
		end else begin
			if (wr.nn_we) begin
				nn_vld_q[wr.nn_addr] <= 1'b1;
			end
			if (wr.po_we) begin
				po_vld_q[wr.po_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.nn_we) begin
			nn_mem[wr.nn_addr] <= wr.nn_data;
		end
		if (rd_en) begin
			nn_rd_q <= nn_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.po_we) begin
			po_mem[wr.po_addr] <= wr.po_data;
		end
		if (rd_en) begin
			po_rd_q <= po_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_id_q     <= rd_id;
			nn_rd_vld_q <= nn_vld_q[rd_addr];
			po_rd_vld_q <= po_vld_q[rd_addr];
		end
	end

	assign rd.nn = nn_rd_vld_q ? nn_rd_q : lot_pkg::nn_init(rd_id_q);
	assign rd.po = po_rd_vld_q ? po_rd_q : lot_pkg::po_init(rd_id_q, count);

endmodule
`default_nettype wire

### hw/rtl/lru_order_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_order_tracker: least recently used order over ids 1..entry_count
// Moves each accessed id to the newest end of a doubly linked order and
// reports the oldest id.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------
//  input    | in_valid/in_stall  | accessed_id
//  output   | out_valid/out_stall| lru_id, rejected
//  config   | cfg_we             | cfg_wdata (entry_count)
//
// A word is handled in ST_IDLE, which reads the links of the id and relinks
// it at the newest end, then in ST_UNLINK, which unlinks it from its old
// place; each link memory has one write port and takes at most one write in each.
// Reset or a write of entry_count restores the initial order at once.
// A stalled output holds the unlink cycle; the next word is taken after it.
// ----------------------------------------------------------------------------
module lru_order_tracker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [lot_pkg::ID_W-1:0] cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [lot_pkg::ID_W-1:0] accessed_id,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [lot_pkg::ID_W-1:0] lru_id,
	output logic                     rejected
);

	lot_pkg::state_t   state_q;
	lot_pkg::state_t   state_d;
	lot_pkg::id_t      count_q;
	lot_pkg::id_t      oldest_q;
	lot_pkg::id_t      newest_q;
	lot_pkg::id_t      cfg_count;
	logic              move_s1;
	logic              rej_s1;
	logic              out_valid_q;
	lot_pkg::id_t      lru_id_q;
	logic              rejected_q;

	logic              in_acc;
	logic              advance;
	logic              id_ok;
	logic              move;
	lot_pkg::id_t      older;
	lot_pkg::id_t      newer;
	lot_pkg::id_t      oldest_d;
	lot_pkg::link_wr_t wr;
	lot_pkg::link_rd_t rd;

	assign cfg_count = lot_pkg::clamp_count(cfg_wdata);
	assign id_ok     = (accessed_id != '0) && (accessed_id <= count_q);
	assign move      = id_ok && (accessed_id != newest_q);
	assign older     = rd.po;
	assign newer     = rd.nn;
	assign oldest_d  = (move_s1 && older == '0) ? newer : oldest_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lot_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lot_pkg::ST_UNLINK;
				end
			end
			lot_pkg::ST_UNLINK: begin
				if (!out_valid_q || !out_stall) begin
					state_d = lot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lot_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		in_acc   = 1'b0;
		advance  = 1'b0;
		wr       = '0;
		case (state_q)
			lot_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				in_acc   = in_valid;
				// relink at the newest end
				wr.nn_we   = in_valid && move;
				wr.nn_addr = lot_pkg::addr_of(newest_q);
				wr.nn_data = accessed_id;
				wr.po_we   = in_valid && move;
				wr.po_addr = lot_pkg::addr_of(accessed_id);
				wr.po_data = newest_q;
			end
			lot_pkg::ST_UNLINK: begin
				advance = !out_valid_q || !out_stall;
				// drop from the old place
				wr.nn_we   = advance && move_s1 && (older != '0);
				wr.nn_addr = lot_pkg::addr_of(older);
				wr.nn_data = newer;
				wr.po_we   = advance && move_s1;
				wr.po_addr = lot_pkg::addr_of(newer);
				wr.po_data = older;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lot_pkg::ST_IDLE;
			count_q     <= lot_pkg::ID_W'(lot_pkg::MAX_ENTRIES);
			oldest_q    <= lot_pkg::ID_W'(lot_pkg::MAX_ENTRIES);
			newest_q    <= lot_pkg::ID_W'(1);
			move_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q  <= cfg_count;
				oldest_q <= cfg_count;
				newest_q <= lot_pkg::ID_W'(1);
			end else begin
				if (in_acc && move) begin
					newest_q <= accessed_id;
				end
				if (advance) begin
					oldest_q <= oldest_d;
				end
			end
			if (in_acc) begin
				move_s1 <= move;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rej_s1 <= !id_ok;
		end
		if (advance) begin
			lru_id_q   <= oldest_d;
			rejected_q <= rej_s1;
		end
	end

	lot_link_mem u_link_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_we),
		.count  (count_q),
		.rd_en  (in_acc),
		.rd_id  (accessed_id),
		.wr     (wr),
		.rd     (rd)
	);

	assign out_valid = out_valid_q;
	assign lru_id    = lru_id_q;
	assign rejected  = rejected_q;

endmodule
`default_nettype wire
